[design/button_gesture_detector_unit_macros.svh]
// Assertion macros for the button gesture detector checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BUTTON_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BGD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BGD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/bgd_pkg.sv]
// Shared types and constants for the button gesture detector.
// No dependencies; imported by every module of the block.
package bgd_pkg;

   localparam int PIN_W   = 16;
   localparam int TICK_W  = 32;
   localparam int CNT_W   = 2;
   localparam int GEST_W  = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_MASK  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK = CSR_IDX_W'(3);

   localparam logic [CSR_DATA_W-1:0] BUTTON_MASK_RST  = 16'd0;
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RST     = 16'd20;
   localparam logic [CSR_DATA_W-1:0] LONG_PRESS_RST   = 16'd500;
   localparam logic [CSR_DATA_W-1:0] DOUBLE_CLICK_RST = 16'd150;

   // gesture codes
   localparam logic [GEST_W-1:0] GEST_CLICK  = 2'd0;
   localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd1;
   localparam logic [GEST_W-1:0] GEST_LONG   = 2'd2;

   localparam logic [CNT_W-1:0] CLICK_SAT = 2'd3;
   localparam logic [CNT_W-1:0] CLICK_TWO = 2'd2;

   typedef struct packed {
      logic [PIN_W-1:0]      button_mask;
      logic [CSR_DATA_W-1:0] debounce_ticks;
      logic [CSR_DATA_W-1:0] long_press_ticks;
      logic [CSR_DATA_W-1:0] double_click_ticks;
   } cfg_type;

   typedef struct packed {
      logic [GEST_W-1:0] gesture;
      logic [PIN_W-1:0]  buttons;
   } result_type;

endpackage

[design/bgd_csr.sv]
// Configuration register file of the button gesture detector.
// Depends on bgd_pkg.
module bgd_csr import bgd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BUTTON_MASK:  cfg_in.button_mask        = csr_wdata;
            CSR_DEBOUNCE:     cfg_in.debounce_ticks     = csr_wdata;
            CSR_LONG_PRESS:   cfg_in.long_press_ticks   = csr_wdata;
            CSR_DOUBLE_CLICK: cfg_in.double_click_ticks = csr_wdata;
            default:          cfg_in = cfg_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_mask        <= BUTTON_MASK_RST;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.long_press_ticks   <= LONG_PRESS_RST;
         cfg_ff.double_click_ticks <= DOUBLE_CLICK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/bgd_engine.sv]
// Gesture state and single-pass update logic for one tick sample.
// Depends on bgd_pkg.
module bgd_engine import bgd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [PIN_W-1:0] pin_levels,
   input  cfg_type          cfg,
   output logic             report,
   output result_type       result
);

   localparam logic [1:0] ES_KEEP = 2'd0;
   localparam logic [1:0] ES_NOW  = 2'd1;
   localparam logic [1:0] ES_ZERO = 2'd2;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [PIN_W-1:0]  pressed_ff, pressed_in;
   logic [PIN_W-1:0]  gset_ff, gset_in;
   logic [TICK_W-1:0] stamp_ff, stamp_in;
   logic [CNT_W-1:0]  clicks_ff, clicks_in;
   logic              long_ff, long_in;

   logic [PIN_W-1:0]  now_set;
   logic [TICK_W-1:0] elapsed;
   logic [TICK_W-1:0] gap;
   logic              changed;
   logic [CNT_W-1:0]  clicks_inc;
   logic [1:0]        stamp_sel;
   logic [PIN_W-1:0]  gset_mid;
   logic [TICK_W-1:0] stamp_mid;
   logic [CNT_W-1:0]  clicks_mid;

   always_comb begin
      tick_in    = tick_ff + TICK_W'(1);
      now_set    = cfg.button_mask & ~pin_levels;
      elapsed    = tick_in - stamp_ff;
      changed    = (now_set != pressed_ff) && (elapsed > TICK_W'(cfg.debounce_ticks));
      clicks_inc = (clicks_ff == CLICK_SAT) ? CLICK_SAT : clicks_ff + CNT_W'(1);

      pressed_in = pressed_ff;
      gset_mid   = gset_ff;
      clicks_mid = clicks_ff;
      long_in    = long_ff;
      stamp_sel  = ES_KEEP;

      if (changed) begin
         if (now_set > pressed_ff) begin
            // press starts: capture the set
            stamp_sel  = ES_NOW;
            pressed_in = now_set;
            gset_mid   = now_set;
         end else if (now_set == '0) begin
            // full release counts one more click
            clicks_mid = clicks_inc;
            pressed_in = '0;
            if (elapsed >= TICK_W'(cfg.long_press_ticks)) begin
               long_in   = 1'b1;
               stamp_sel = ES_ZERO;
            end else begin
               long_in   = 1'b0;
               stamp_sel = (clicks_inc > CNT_W'(1)) ? ES_ZERO : ES_NOW;
            end
         end else begin
            // partial release: restart timing only
            stamp_sel = ES_NOW;
         end
      end

      // quiet time against the updated stamp, picked without a second subtract
      case (stamp_sel)
         ES_NOW: begin
            stamp_mid = tick_in;
            gap       = '0;
         end
         ES_ZERO: begin
            stamp_mid = '0;
            gap       = tick_in;
         end
         default: begin
            stamp_mid = stamp_ff;
            gap       = elapsed;
         end
      endcase

      report = (gap > TICK_W'(cfg.double_click_ticks)) && (clicks_mid != '0);

      if (long_in)
         result.gesture = GEST_LONG;
      else if (clicks_mid == CLICK_TWO)
         result.gesture = GEST_DOUBLE;
      else
         result.gesture = GEST_CLICK;
      result.buttons = gset_mid;

      if (report) begin
         clicks_in = '0;
         stamp_in  = '0;
         gset_in   = '0;
      end else begin
         clicks_in = clicks_mid;
         stamp_in  = stamp_mid;
         gset_in   = gset_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         pressed_ff <= '0;
         gset_ff    <= '0;
         stamp_ff   <= '0;
         clicks_ff  <= '0;
         long_ff    <= 1'b0;
      end else if (step) begin
         tick_ff    <= tick_in;
         pressed_ff <= pressed_in;
         gset_ff    <= gset_in;
         stamp_ff   <= stamp_in;
         clicks_ff  <= clicks_in;
         long_ff    <= long_in;
      end
   end

endmodule

[design/button_gesture_detector_unit.sv]
// Top level of the button gesture detector: input word register, gesture
// engine, result register and configuration port. Depends on bgd_pkg,
// bgd_csr and bgd_engine.
//
//   channel | direction | payload                               | handshake
//   req     | in        | tdata[15:0] pin_levels                | tvalid/tready
//   rsp     | out       | tdata[15:0] buttons, tuser[1:0] gesture | tvalid/tready
//   csr     | in        | index[3:0], wdata[15:0]               | valid/ready
//
// One word per cycle sustained while rsp is not stalled. A word is held in the
// input register; its result, if any, is then loaded into the result register
// and stays on rsp until taken. The state update is one pass of compares.
// Reset is synchronous and active high; it clears the state, the tick count
// and restores the configuration defaults.
// A stalled result holds the input register, which then drops req_tready.
module button_gesture_detector_unit import bgd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIN_W-1:0]      req_tdata,   // [15:0] pin_levels
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIN_W-1:0]      rsp_tdata,   // [15:0] buttons
   output logic [GEST_W-1:0]     rsp_tuser,   // [1:0] gesture
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic             in_valid_ff, in_valid_in;
   logic [PIN_W-1:0] pins_ff, pins_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;

   logic       out_free;
   logic       process;
   logic       req_take;
   logic       report;
   result_type result;

   bgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (process),
      .pin_levels (pins_ff),
      .cfg        (cfg),
      .report     (report),
      .result     (result)
   );

   // Advance the held word whenever the result register can take a result,
   // whether or not this tick produces one.
   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      process    = in_valid_ff && out_free;
      req_tready = !in_valid_ff || process;
      req_take   = req_tvalid && req_tready;

      if (req_take)
         in_valid_in = 1'b1;
      else if (process)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;
      pins_in = req_take ? req_tdata : pins_ff;

      // load a result when the tick reports; otherwise drop a taken one
      if (process)
         out_valid_in = report;
      else if (rsp_tready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
      out_in = (process && report) ? result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      pins_ff <= pins_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.buttons;
   assign rsp_tuser  = out_ff.gesture;

endmodule

[design/bgd_checker.sv]
// Port-level checks for the button gesture detector, bound to the top level.
// Depends on bgd_pkg and button_gesture_detector_unit_macros.svh.
`include "button_gesture_detector_unit_macros.svh"

module bgd_checker import bgd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [PIN_W-1:0]      rsp_tdata,
   input logic [GEST_W-1:0]     rsp_tuser
);

   // a fresh result always comes from a word taken straight through the input register into the result register
   `BGD_ASSERT_IMP(a_result_follows_word, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "result without a matching input word")

   // input back-pressure only comes from a stalled result
   `BGD_ASSERT_IMP(a_ready_low_on_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "req_tready low without a stalled result")

   // hold a stalled result
   `BGD_ASSERT_NXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind button_gesture_detector_unit bgd_checker u_bgd_checker (.*);
